// File: hw/rtl/mksc_pkg.sv
// shared types and constants for the morse key symbol collector
package mksc_pkg;

  // default timer width and config reset values
  localparam int TimerWidthDef = 16;
  localparam logic [15:0] DashThresholdRst = 16'd500;
  localparam logic [15:0] PhantomLimitRst = 16'd10;
  localparam logic [15:0] IdleTimeoutRst = 16'd5000;
  localparam logic [2:0] MaxSymbolsRst = 3'd5;

  // config port geometry
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 16;

  // code word geometry
  localparam int CodeWidth = 8;
  localparam int CountWidth = 3;
  localparam logic [CodeWidth-1:0] CodeEmpty = 8'd1;

  // result queue geometry
  localparam int OqDepth = 4;
  localparam int OqPtrWidth = $clog2(OqDepth);
  localparam int OqCntWidth = $clog2(OqDepth + 1);

  // register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DASH_THRESHOLD = 2'd0,
    REG_PHANTOM_LIMIT = 2'd1,
    REG_IDLE_TIMEOUT = 2'd2,
    REG_MAX_SYMBOLS = 2'd3
  } reg_index_t;

  // result kinds
  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_OVERFLOW = 1'b1
  } kind_t;

  // one result beat
  typedef struct packed {
    kind_t kind;
    logic [CodeWidth-1:0] code;
    logic last;
  } result_t;

endpackage

// File: hw/rtl/morse_key_symbol_collector.sv
// morse key symbol collector: key sample decode and result queue
//
// Input channel: one key_down sample per beat (in_valid / in_stall); each
// beat stands for one millisecond tick. Output channel: result beats with
// kind, code and last (out_valid / out_stall). A sample makes zero, one or
// two results: an overflow word on a release past max_symbols, then the idle
// word once the key has been up longer than idle_timeout.
// Throughput: one sample per cycle while in_stall is low. The whole decode is
// one pass of logic between the sample and a four-entry result queue, so the
// results of a sample are written to the queue by the edge that takes it.
// in_stall is high while the queue has fewer than two free entries; behind a
// stalled receiver, samples keep flowing until three or more results wait.
// Config writes (cfg_we, cfg_index, cfg_data) are registered and should
// be made while the block is idle.
// Reset (rst, synchronous): config returns to 500 / 10 / 5000 / 5, the key
// is taken as up, the timer and symbol count are zero, the code word is the
// empty sentinel and the result queue is emptied.
module morse_key_symbol_collector
  import mksc_pkg::*;
#(
  parameter int TIMER_WIDTH = TimerWidthDef
) (
  input  logic                     clk,
  input  logic                     rst,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     key_down,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     kind,
  output logic [CodeWidth-1:0]     code,
  output logic                     last,
  // config port
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  localparam int CmpWidth = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // config registers
  logic [15:0] dash_threshold;
  logic [15:0] phantom_limit;
  logic [15:0] idle_timeout;
  logic [2:0]  max_symbols;

  // decode state
  logic                   key_held;
  logic [TIMER_WIDTH-1:0] elapsed_ms;
  logic [CountWidth-1:0]  symbol_count;
  logic [CodeWidth-1:0]   code_word;

  logic [TIMER_WIDTH-1:0] elapsed_ms_next;
  logic [CountWidth-1:0]  symbol_count_next;
  logic [CodeWidth-1:0]   code_word_next;

  // result queue
  result_t               oq [OqDepth];
  logic [OqPtrWidth-1:0] rd_ptr;
  logic [OqPtrWidth-1:0] wr_ptr;
  logic [OqCntWidth-1:0] oq_count;
  logic [OqCntWidth-1:0] oq_count_next;

  logic                  in_beat;
  logic                  out_beat;
  logic                  press;
  logic                  release_ev;
  logic                  overflow;
  logic                  idle;
  logic                  is_dash;
  logic                  is_real;
  logic [TIMER_WIDTH-1:0] el_step;
  logic [CountWidth-1:0] cnt_rel;
  logic [CodeWidth-1:0]  cw_rel;
  result_t               res0;
  result_t               res1;
  logic [1:0]            push_n;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // handshake toward both sides
  assign in_stall  = (oq_count > OqCntWidth'(OqDepth - 2));
  assign out_valid = (oq_count != '0);
  assign kind      = oq[rd_ptr].kind;
  assign code      = oq[rd_ptr].code;
  assign last      = oq[rd_ptr].last;

  // press / release detection and hold classification
  always_comb begin
    press      = key_down && !key_held;
    release_ev = !key_down && key_held;
    el_step    = press ? '0 : (elapsed_ms + TIMER_WIDTH'(1));
    is_real    = (CmpWidth'(el_step) >= CmpWidth'(phantom_limit));
    is_dash    = (CmpWidth'(el_step) > CmpWidth'(dash_threshold));
    overflow   = release_ev && (symbol_count >= max_symbols);
    cnt_rel    = symbol_count;
    cw_rel     = code_word;
    if (release_ev) begin
      if (overflow) begin
        cnt_rel = '0;
        cw_rel  = CodeEmpty;
      end else begin
        cnt_rel = symbol_count + CountWidth'(1);
        if (is_real) begin
          cw_rel = {code_word[CodeWidth-2:0], is_dash};
        end
      end
    end
    idle = !key_down && (CmpWidth'(el_step) > CmpWidth'(idle_timeout));
  end

  // idle emission and next decode state
  always_comb begin
    elapsed_ms_next   = el_step;
    symbol_count_next = cnt_rel;
    code_word_next    = cw_rel;
    if (idle) begin
      elapsed_ms_next   = '0;
      symbol_count_next = '0;
      code_word_next    = CodeEmpty;
    end
  end

  // results of this beat, overflow first
  always_comb begin
    res1.kind = KIND_WORD;
    res1.code = cw_rel;
    res1.last = 1'b1;
    if (overflow) begin
      res0.kind = KIND_OVERFLOW;
      res0.code = code_word;
      res0.last = !idle;
    end else begin
      res0 = res1;
    end
    push_n = in_beat ? (2'(overflow) + 2'(idle)) : 2'd0;
  end

  // queue occupancy
  always_comb begin
    oq_count_next = oq_count + OqCntWidth'(push_n) - OqCntWidth'(out_beat);
  end

  // decode state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_held     <= 1'b0;
      elapsed_ms   <= '0;
      symbol_count <= '0;
      code_word    <= CodeEmpty;
    end else if (in_beat) begin
      key_held     <= key_down;
      elapsed_ms   <= elapsed_ms_next;
      symbol_count <= symbol_count_next;
      code_word    <= code_word_next;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dash_threshold <= DashThresholdRst;
      phantom_limit  <= PhantomLimitRst;
      idle_timeout   <= IdleTimeoutRst;
      max_symbols    <= MaxSymbolsRst;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_DASH_THRESHOLD: dash_threshold <= cfg_data;
        REG_PHANTOM_LIMIT:  phantom_limit  <= cfg_data;
        REG_IDLE_TIMEOUT:   idle_timeout   <= cfg_data;
        REG_MAX_SYMBOLS:    max_symbols    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      oq_count <= '0;
    end else begin
      rd_ptr   <= rd_ptr + OqPtrWidth'(out_beat);
      wr_ptr   <= wr_ptr + OqPtrWidth'(push_n);
      oq_count <= oq_count_next;
    end
  end

  // queue storage, up to two writes per beat
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq[wr_ptr] <= res0;
    end
    if (push_n == 2'd2) begin
      oq[wr_ptr + OqPtrWidth'(1)] <= res1;
    end
  end

  // queue never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    oq_count <= OqCntWidth'(OqDepth))
    else $error("result queue over capacity");

  // code word keeps its sentinel
  assert property (@(posedge clk) disable iff (rst)
    code_word != '0)
    else $error("code word lost its sentinel");

  // a double result is overflow then idle word
  assert property (@(posedge clk) disable iff (rst)
    push_n == 2'd2 |-> res0.kind == KIND_OVERFLOW && !res0.last && res1.last)
    else $error("bad ordering of a double result");

  // a sample with a result leaves the output valid on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |=> out_valid)
    else $error("result not presented");

endmodule

// File: bench/mksc_result_checker.sv
`timescale 1ns / 1ps
// result checker for the morse key symbol collector: tracks decode state, predicts beats
module mksc_result_checker
  import mksc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     key_down,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     kind,
  input  logic [CodeWidth-1:0]     code,
  input  logic                     last,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output int                       errors,
  output int                       pending
);

  // shadow of the config registers
  logic [15:0] dash_thr;
  logic [15:0] phantom_lim;
  logic [15:0] idle_tmo;
  logic [CountWidth-1:0] max_sym;

  // shadow of the decode state
  logic key_prev;
  logic key_hold;
  logic [TimerWidthDef-1:0] elapsed;
  logic [CountWidth-1:0] sym_count;
  logic [CodeWidth-1:0] word;

  // words still owed by the block, oldest first
  result_t owed_words[$];
  int beat_no;

  initial begin
    errors = 0;
    pending = 0;
    beat_no = 0;
  end

  task automatic report(input string msg);
    errors++;
    $display("[%0t] mismatch on result beat %0d: %s", $time, beat_no, msg);
  endtask

  // one millisecond tick of the key decoder
  task automatic decode_tick(input logic level);
    result_t fresh[2];
    int n;
    logic [CountWidth:0] next_count;
    n = 0;
    elapsed = elapsed + 1'b1;

    if (level && !key_prev) begin
      // press: restart the hold timer
      elapsed = '0;
      key_prev = 1'b1;
      key_hold = 1'b1;
    end else if (!level && key_prev) begin
      // release: every release counts, phantom holds add no symbol
      next_count = {1'b0, sym_count} + 1'b1;
      key_prev = 1'b0;
      if (next_count > {1'b0, max_sym}) begin
        fresh[n] = '{kind: KIND_OVERFLOW, code: word, last: 1'b0};
        n++;
        word = CodeEmpty;
        sym_count = '0;
      end else begin
        sym_count = next_count[CountWidth-1:0];
        if (elapsed >= phantom_lim)
          word = {word[CodeWidth-2:0], (elapsed > dash_thr)};
      end
      key_hold = 1'b0;
    end

    // key up long enough: flush the word, even an empty one
    if (!key_hold && elapsed > idle_tmo) begin
      fresh[n] = '{kind: KIND_WORD, code: word, last: 1'b0};
      n++;
      elapsed = '0;
      sym_count = '0;
      word = CodeEmpty;
    end

    if (n > 0) fresh[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) owed_words.push_back(fresh[i]);
  endtask

  // everything sampled on the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      dash_thr = DashThresholdRst;
      phantom_lim = PhantomLimitRst;
      idle_tmo = IdleTimeoutRst;
      max_sym = MaxSymbolsRst;
      key_prev = 1'b0;
      key_hold = 1'b0;
      elapsed = '0;
      sym_count = '0;
      word = CodeEmpty;
      owed_words.delete();
    end else begin
      // result beat against the oldest owed word
      if (out_valid && !out_stall) begin
        beat_no++;
        if (owed_words.size() == 0) begin
          report($sformatf("unexpected beat kind %0d code 0x%02h last %0d", kind, code, last));
        end else begin
          want = owed_words.pop_front();
          if (kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (code !== want.code)
            report($sformatf("code 0x%02h, expected 0x%02h", code, want.code));
          if (last !== want.last)
            report($sformatf("last %0d, expected %0d", last, want.last));
        end
      end

      // sample beat
      if (in_valid && !in_stall) decode_tick(key_down);

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_DASH_THRESHOLD: dash_thr = cfg_data;
          REG_PHANTOM_LIMIT:  phantom_lim = cfg_data;
          REG_IDLE_TIMEOUT:   idle_tmo = cfg_data;
          REG_MAX_SYMBOLS:    max_sym = cfg_data[CountWidth-1:0];
          default: ;
        endcase
      end
    end
    pending = owed_words.size();
  end

endmodule

// File: bench/tb_morse_key_symbol_collector.sv
`timescale 1ns / 1ps
// testbench top for the morse key symbol collector: key stimulus, config phases, verdict
module tb_morse_key_symbol_collector;
  import mksc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic key_down = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic [CodeWidth-1:0] code;
  logic last;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = REG_DASH_THRESHOLD;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  int errors;
  int pending;
  int burst_left = 0;
  int samples_sent = 0;
  int cur_dash = 500;
  int cur_idle = 5000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 0;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  morse_key_symbol_collector uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_down  (key_down),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .code      (code),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mksc_result_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_down  (key_down),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .code      (code),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // receiver back-pressure, mode changes every so often
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((stall_left / 8) % 2 == 1);
      endcase
    end
  end

  // one sample beat, sent in bursts with random gaps
  task automatic send_key(input logic level);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        key_down <= 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    key_down <= level;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic level, input int ticks);
    repeat (ticks) send_key(level);
  endtask

  // drain all owed words and let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all four registers while idle
  task automatic apply_config(input int dash, input int phantom, input int idle, input int maxs);
    logic [CfgDataWidth-CountWidth-1:0] pad;
    wait_idle();
    pad = (CfgDataWidth-CountWidth)'($urandom);
    cur_dash = dash;
    cur_idle = idle;
    cfg_we <= 1'b1;
    cfg_index <= REG_DASH_THRESHOLD;
    cfg_data <= dash[15:0];
    @(negedge clk);
    cfg_index <= REG_PHANTOM_LIMIT;
    cfg_data <= phantom[15:0];
    @(negedge clk);
    cfg_index <= REG_IDLE_TIMEOUT;
    cfg_data <= idle[15:0];
    @(negedge clk);
    // upper bits of the count write are don't-care
    cfg_index <= REG_MAX_SYMBOLS;
    cfg_data <= {pad, maxs[CountWidth-1:0]};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly keyed symbols with random holds and gaps, some raw noise
  task automatic run_phase(input int budget);
    int target;
    int hold_cap;
    int gap_cap;
    int r;
    target = samples_sent + budget;
    hold_cap = (cur_dash < 37) ? cur_dash + 3 : 40;
    gap_cap = (cur_idle < 40) ? cur_idle : 40;
    if (gap_cap < 1) gap_cap = 1;
    while (samples_sent < target) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 6)) send_key(1'($urandom_range(0, 1)));
      end else begin
        send_run(1'b1, $urandom_range(1, hold_cap));
        if (r <= 2) send_run(1'b0, gap_cap + $urandom_range(1, 3));
        else send_run(1'b0, $urandom_range(1, gap_cap));
      end
    end
  endtask

  // main stimulus
  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phantom, dot, dash, overflow together with idle flush, empty flush
    apply_config(3, 2, 6, 3);
    send_run(1'b0, 2);
    send_run(1'b1, 1);
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 4);
    send_run(1'b0, 1);
    send_run(1'b1, 8);
    send_run(1'b0, 1);
    send_run(1'b0, 7);

    // zero symbol limit: every release overflows
    apply_config(3, 2, 6, 0);
    send_run(1'b1, 2);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 1);

    // full eight-bit word, then overflow carrying it
    apply_config(1, 1, 65535, 7);
    for (int i = 0; i < 8; i++) begin
      send_run(1'b1, 1 + (i % 2));
      send_run(1'b0, 1);
    end

    // all thresholds zero: every hold a dash, flush on each idle tick
    apply_config(0, 0, 0, 7);
    send_run(1'b1, 1);
    send_run(1'b0, 2);

    // random phases, extremes first
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: apply_config(0, 0, 0, 1);
        1: apply_config(65535, 65535, 65535, 7);
        default: apply_config($urandom_range(1, 12), $urandom_range(0, 4),
                              $urandom_range(3, 30), $urandom_range(1, 7));
      endcase
      run_phase(52);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mksc_pkg.sv
hw/rtl/morse_key_symbol_collector.sv
bench/mksc_result_checker.sv
bench/tb_morse_key_symbol_collector.sv
